// ----- rtl/core/idll_pkg.sv -----
// Shared constants, codes and control types of the linked list engine.
`default_nettype none

package idll_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int MAX_TAKE   = 63;
	localparam int CNT_W      = 6;
	localparam int SUM_W      = 32;
	localparam int KIND_W     = 2;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPLICE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TAKE   = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_SPL_RD,
		ST_SPL_UNLINK,
		ST_SPL_RDC,
		ST_SPL_LINK,
		ST_SPL_CLOSE,
		ST_TAKE_RD,
		ST_TAKE_WR,
		ST_TAKE_SUM
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_INS_RD,
		DP_INS_WR,
		DP_SPL_RD,
		DP_SPL_UNLINK,
		DP_SPL_RDC,
		DP_SPL_LINK,
		DP_SPL_CLOSE,
		DP_TAKE_RD,
		DP_TAKE_WR,
		DP_TAKE_SUM
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic take_go;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/indexed_doubly_linked_list_engine.sv -----
// Top level of the indexed doubly linked list engine: stream ports, controller and datapath.
// After reset the block sweeps all 1024 nodes of both link memories to zero, one node a
// cycle, and holds s_tready low until the sweep is done. One item is worked at a time: an
// insert reads node b's link and then writes the remaining links, a splice reads, unlinks,
// reads node c's link, links and closes, and a take removes nodes one by one; its steps
// stall while the result register waits on m_tready. This order is set by the link
// memories, each of which does one read and one write a cycle, and by the walk, in which
// every removal reads a node's links before it rewrites its neighbors. Kind 3 is accepted
// and dropped. Each take ends with a summary beat that has m_tlast high and node id 0.
`default_nettype none

module indexed_doubly_linked_list_engine
	import idll_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // node_a[9:0], node_b[19:10], node_c[29:20],
	                                   // count[35:30], side[36], zero[39:37]
	input  wire logic [1:0]  s_tuser,  // kind[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,  // removed_node[9:0], shortfall_total[41:10], zero[47:42]
	output logic             m_tlast
);

	dp_cmd_t           cmd;
	dp_sts_t           sts;
	logic [NODE_W-1:0] out_node;
	logic [SUM_W-1:0]  out_sum;

	idll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	idll_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_node_a (s_tdata[9:0]),
		.in_node_b (s_tdata[19:10]),
		.in_node_c (s_tdata[29:20]),
		.in_count  (s_tdata[35:30]),
		.in_side   (s_tdata[36]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_node  (out_node),
		.out_sum   (out_sum),
		.out_last  (m_tlast)
	);

	assign m_tdata = {6'd0, out_sum, out_node};

endmodule

`default_nettype wire

// ----- rtl/core/idll_ctrl.sv -----
// Controller state machine that sequences link reads and writes for each item.
`default_nettype none

module idll_ctrl
	import idll_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [KIND_W-1:0] in_kind,
	output logic                   in_ready,
	output dp_cmd_t                cmd,
	input  wire dp_sts_t           sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = DP_NOP;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = DP_CLEAR;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = DP_LOAD;
					unique case (in_kind)
						KIND_INSERT: state_d = ST_INS_RD;
						KIND_SPLICE: state_d = ST_SPL_RD;
						KIND_TAKE:   state_d = ST_TAKE_RD;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_INS_RD: begin
				cmd.op  = DP_INS_RD;
				state_d = ST_INS_WR;
			end
			ST_INS_WR: begin
				cmd.op  = DP_INS_WR;
				state_d = ST_IDLE;
			end
			ST_SPL_RD: begin
				cmd.op  = DP_SPL_RD;
				state_d = ST_SPL_UNLINK;
			end
			ST_SPL_UNLINK: begin
				cmd.op  = DP_SPL_UNLINK;
				state_d = ST_SPL_RDC;
			end
			ST_SPL_RDC: begin
				cmd.op  = DP_SPL_RDC;
				state_d = ST_SPL_LINK;
			end
			ST_SPL_LINK: begin
				cmd.op  = DP_SPL_LINK;
				state_d = ST_SPL_CLOSE;
			end
			ST_SPL_CLOSE: begin
				cmd.op  = DP_SPL_CLOSE;
				state_d = ST_IDLE;
			end
			ST_TAKE_RD: begin
				if (sts.take_go) begin
					cmd.op  = DP_TAKE_RD;
					state_d = ST_TAKE_WR;
				end else begin
					state_d = ST_TAKE_SUM;
				end
			end
			ST_TAKE_WR: begin
				if (sts.out_free) begin
					cmd.op  = DP_TAKE_WR;
					state_d = ST_TAKE_RD;
				end
			end
			ST_TAKE_SUM: begin
				if (sts.out_free) begin
					cmd.op  = DP_TAKE_SUM;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/core/idll_dp.sv -----
// Datapath: link memories, item registers, take walk counters and result register.
`default_nettype none

module idll_dp
	import idll_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_sts_t                sts,
	input  wire logic [NODE_W-1:0] in_node_a,
	input  wire logic [NODE_W-1:0] in_node_b,
	input  wire logic [NODE_W-1:0] in_node_c,
	input  wire logic [CNT_W-1:0]  in_count,
	input  wire logic              in_side,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [NODE_W-1:0]      out_node,
	output logic [SUM_W-1:0]       out_sum,
	output logic                   out_last
);

	logic [NODE_W-1:0] prev_mem [NODE_COUNT];
	logic [NODE_W-1:0] next_mem [NODE_COUNT];

	logic [NODE_W-1:0] a_q, b_q, c_q, now_q, clr_q;
	logic [CNT_W-1:0]  left_q, steps_q;
	logic              side_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NODE_W-1:0] prev_rd_q, next_rd_q;

	logic              out_valid_q, out_last_q;
	logic [NODE_W-1:0] out_node_q;
	logic [SUM_W-1:0]  out_sum_q;

	logic              prev_we, next_we, prev_re, next_re;
	logic [NODE_W-1:0] prev_waddr, prev_wdata, prev_raddr;
	logic [NODE_W-1:0] next_waddr, next_wdata, next_raddr;

	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_new;
	logic              out_free;

	assign sum_ext  = {1'b0, sum_q} + {{(SUM_W+1-CNT_W){1'b0}}, left_q};
	assign sum_new  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	assign sts.clr_last = (clr_q == NODE_W'(NODE_COUNT - 1));
	assign sts.take_go  = (left_q != '0) && (now_q != '0) && (steps_q < CNT_W'(MAX_TAKE));
	assign sts.out_free = out_free;

	// Port control of both link memories. Insert uses the "near" memory for the
	// links that point toward the anchor side, the other memory for the far links.
	always_comb begin
		prev_we    = 1'b0;
		next_we    = 1'b0;
		prev_re    = 1'b0;
		next_re    = 1'b0;
		prev_waddr = '0;
		prev_wdata = '0;
		prev_raddr = '0;
		next_waddr = '0;
		next_wdata = '0;
		next_raddr = '0;
		unique case (cmd.op)
			DP_CLEAR: begin
				prev_we    = 1'b1;
				prev_waddr = clr_q;
				next_we    = 1'b1;
				next_waddr = clr_q;
			end
			DP_INS_RD: begin
				if (side_q) begin
					prev_re    = 1'b1;
					prev_raddr = b_q;
					prev_we    = 1'b1;
					prev_waddr = b_q;
					prev_wdata = a_q;
					next_we    = 1'b1;
					next_waddr = a_q;
					next_wdata = b_q;
				end else begin
					next_re    = 1'b1;
					next_raddr = b_q;
					next_we    = 1'b1;
					next_waddr = b_q;
					next_wdata = a_q;
					prev_we    = 1'b1;
					prev_waddr = a_q;
					prev_wdata = b_q;
				end
			end
			DP_INS_WR: begin
				prev_we = 1'b1;
				next_we = 1'b1;
				if (side_q) begin
					prev_waddr = a_q;
					prev_wdata = prev_rd_q;
					next_waddr = prev_rd_q;
					next_wdata = a_q;
				end else begin
					next_waddr = a_q;
					next_wdata = next_rd_q;
					prev_waddr = next_rd_q;
					prev_wdata = a_q;
				end
			end
			DP_SPL_RD: begin
				prev_re    = 1'b1;
				prev_raddr = a_q;
				next_re    = 1'b1;
				next_raddr = b_q;
			end
			DP_SPL_UNLINK, DP_TAKE_WR: begin
				next_we    = 1'b1;
				next_waddr = prev_rd_q;
				next_wdata = next_rd_q;
				prev_we    = 1'b1;
				prev_waddr = next_rd_q;
				prev_wdata = prev_rd_q;
			end
			DP_SPL_RDC: begin
				prev_re    = 1'b1;
				prev_raddr = c_q;
			end
			DP_SPL_LINK: begin
				next_we    = 1'b1;
				next_waddr = prev_rd_q;
				next_wdata = a_q;
				prev_we    = 1'b1;
				prev_waddr = a_q;
				prev_wdata = prev_rd_q;
			end
			DP_SPL_CLOSE: begin
				prev_we    = 1'b1;
				prev_waddr = c_q;
				prev_wdata = b_q;
				next_we    = 1'b1;
				next_waddr = b_q;
				next_wdata = c_q;
			end
			DP_TAKE_RD: begin
				prev_re    = 1'b1;
				prev_raddr = now_q;
				next_re    = 1'b1;
				next_raddr = now_q;
			end
			DP_NOP, DP_LOAD, DP_TAKE_SUM: begin
			end
			default: begin
			end
		endcase
	end

	// A read in the same cycle as a write to the same entry returns the old link.
	always_ff @(posedge clk) begin
		if (prev_re) begin
			prev_rd_q <= prev_mem[prev_raddr];
		end
		if (prev_we) begin
			prev_mem[prev_waddr] <= prev_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (next_re) begin
			next_rd_q <= next_mem[next_raddr];
		end
		if (next_we) begin
			next_mem[next_waddr] <= next_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_LOAD) begin
			a_q    <= in_node_a;
			b_q    <= in_node_b;
			c_q    <= in_node_c;
			side_q <= in_side;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			sum_q   <= '0;
			left_q  <= '0;
			steps_q <= '0;
			now_q   <= '0;
		end else begin
			if (cmd.op == DP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.op == DP_LOAD) begin
				left_q  <= in_count;
				steps_q <= '0;
				now_q   <= in_node_a;
			end
			if (cmd.op == DP_TAKE_WR) begin
				left_q  <= left_q - 1'b1;
				steps_q <= steps_q + 1'b1;
				now_q   <= side_q ? prev_rd_q : next_rd_q;
			end
			if (cmd.op == DP_TAKE_SUM) begin
				sum_q <= sum_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == DP_TAKE_WR || cmd.op == DP_TAKE_SUM) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_TAKE_WR) begin
			out_node_q <= now_q;
			out_sum_q  <= sum_q;
			out_last_q <= 1'b0;
		end else if (cmd.op == DP_TAKE_SUM) begin
			out_node_q <= '0;
			out_sum_q  <= sum_new;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_node  = out_node_q;
	assign out_sum   = out_sum_q;
	assign out_last  = out_last_q;

	a_sum_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> sum_q >= $past(sum_q))
		else $error("shortfall total decreased");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_TAKE_WR || cmd.op == DP_TAKE_SUM) |-> out_free)
		else $error("result beat issued while output register is held");

	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= CNT_W'(MAX_TAKE))
		else $error("take walk exceeded its node limit");

	a_summary_node_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> (out_node_q == '0))
		else $error("summary beat carries a node id");

endmodule

`default_nettype wire
